// ----- rtl/dlss_pkg.sv -----
package dlss_pkg;

  localparam int unsigned PeriodBits = 16;
  localparam int unsigned TimeBits   = 16;

  localparam int unsigned CfgDataW = 16;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned LimitW   = 4;
  localparam int unsigned HystW    = LimitW + 1;

  localparam int unsigned PerCmpW  = (PeriodBits > CfgDataW) ? PeriodBits : CfgDataW;
  localparam int unsigned TimeCmpW = (TimeBits > CfgDataW) ? TimeBits : CfgDataW;

  localparam int unsigned ReqTypeW  = 3;
  localparam int unsigned RelayW    = 2;
  localparam int unsigned RespW     = 8;
  localparam int unsigned InFieldsW = PeriodBits + RelayW + RespW + 1;
  localparam int unsigned InDataW   = ((InFieldsW + 7) / 8) * 8;
  localparam int unsigned OutFieldsW = 2 + 1 + 1 + 1 + HystW;
  localparam int unsigned OutDataW   = ((OutFieldsW + 7) / 8) * 8;

  localparam int unsigned InRelayLsb = PeriodBits;
  localparam int unsigned InRespLsb  = InRelayLsb + RelayW;
  localparam int unsigned InTreqLsb  = InRespLsb + RespW;

  localparam logic [CfgDataW-1:0] MinPeriodRst    = CfgDataW'(15300);
  localparam logic [CfgDataW-1:0] MaxPeriodRst    = CfgDataW'(22200);
  localparam logic [LimitW-1:0]   HystLimitRst    = LimitW'(2);
  localparam logic [CfgDataW-1:0] CheckIntervalRst = CfgDataW'(100);
  localparam logic [CfgDataW-1:0] ReqWindowRst    = CfgDataW'(4000);
  localparam logic [CfgDataW-1:0] SettleRst       = CfgDataW'(300);

  localparam logic [RespW-1:0]  RespGrantA  = RespW'(1);
  localparam logic [RespW-1:0]  RespGrantB  = RespW'(2);
  localparam int unsigned       RespDenyBit = 7;

  localparam logic [RelayW-1:0] RelayOff     = RelayW'(0);
  localparam logic [RelayW-1:0] RelayUnknown = RelayW'(2);

  typedef enum logic [ReqTypeW-1:0] {
    REQ_CAPTURE   = 3'd0,
    REQ_OVERFLOW  = 3'd1,
    REQ_TICK      = 3'd2,
    REQ_RESPONSE  = 3'd3,
    REQ_TRIAC_SET = 3'd4
  } req_type_e;

  typedef enum logic [1:0] {
    LOCK_UNKNOWN  = 2'd0,
    LOCK_UNLOCKED = 2'd1,
    LOCK_LOCKED   = 2'd2
  } lock_state_e;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MIN_PERIOD     = 3'd0,
    CFG_MAX_PERIOD     = 3'd1,
    CFG_HYST_LIMIT     = 3'd2,
    CFG_CHECK_INTERVAL = 3'd3,
    CFG_REQ_WINDOW     = 3'd4,
    CFG_SETTLE         = 3'd5
  } cfg_idx_e;

  typedef struct packed {
    logic [CfgDataW-1:0] min_period;
    logic [CfgDataW-1:0] max_period;
    logic [LimitW-1:0]   hyst_limit;
    logic [CfgDataW-1:0] check_interval_ms;
    logic [CfgDataW-1:0] request_window_ms;
    logic [CfgDataW-1:0] settle_ms;
  } cfg_t;

  typedef struct packed {
    logic [ReqTypeW-1:0]   req_type;
    logic [PeriodBits-1:0] period;
    logic [RelayW-1:0]     relay_state;
    logic [RespW-1:0]      response_code;
    logic                  triac_request;
  } item_t;

  typedef struct packed {
    logic [1:0]              lock_state;
    logic                    triac_on;
    logic                    timer_ok;
    logic                    request_open;
    logic signed [HystW-1:0] hyst_count;
  } result_t;

endpackage

// ----- rtl/dlss_cfg_regs.sv -----
module dlss_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dlss_pkg::CfgIdxW-1:0]  cfg_addr_i,
  input  logic [dlss_pkg::CfgDataW-1:0] cfg_data_i,
  output dlss_pkg::cfg_t                cfg_o
);

  dlss_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_addr_i)
        dlss_pkg::CFG_MIN_PERIOD:     cfg_d.min_period        = cfg_data_i;
        dlss_pkg::CFG_MAX_PERIOD:     cfg_d.max_period        = cfg_data_i;
        dlss_pkg::CFG_HYST_LIMIT:     cfg_d.hyst_limit        = cfg_data_i[dlss_pkg::LimitW-1:0];
        dlss_pkg::CFG_CHECK_INTERVAL: cfg_d.check_interval_ms = cfg_data_i;
        dlss_pkg::CFG_REQ_WINDOW:     cfg_d.request_window_ms = cfg_data_i;
        dlss_pkg::CFG_SETTLE:         cfg_d.settle_ms         = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.min_period        <= dlss_pkg::MinPeriodRst;
      cfg_q.max_period        <= dlss_pkg::MaxPeriodRst;
      cfg_q.hyst_limit        <= dlss_pkg::HystLimitRst;
      cfg_q.check_interval_ms <= dlss_pkg::CheckIntervalRst;
      cfg_q.request_window_ms <= dlss_pkg::ReqWindowRst;
      cfg_q.settle_ms         <= dlss_pkg::SettleRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- rtl/dlss_core.sv -----
module dlss_core (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               step_i,
  input  dlss_pkg::item_t    item_i,
  input  dlss_pkg::cfg_t     cfg_i,
  output dlss_pkg::result_t  result_o
);

  localparam logic [dlss_pkg::TimeBits-1:0] TimeMax = '1;

  logic signed [dlss_pkg::HystW-1:0] hyst_q, hyst_d;
  dlss_pkg::lock_state_e             door_q, door_d;
  logic                              resolved_q, resolved_d;
  logic [dlss_pkg::TimeBits-1:0]     settle_q, settle_d;
  logic [dlss_pkg::TimeBits-1:0]     check_q, check_d;
  logic                              seen_q, seen_d;
  logic                              healthy_q, healthy_d;
  logic                              win_open_q, win_open_d;
  logic [dlss_pkg::TimeBits-1:0]     win_q, win_d;
  logic                              triac_q, triac_d;

  logic signed [dlss_pkg::HystW-1:0] limit_pos;
  logic signed [dlss_pkg::HystW-1:0] limit_neg;
  logic                              in_range;
  logic [dlss_pkg::TimeBits-1:0]     check_inc;
  logic [dlss_pkg::TimeBits-1:0]     win_inc;
  logic [dlss_pkg::TimeBits-1:0]     settle_inc;

  function automatic logic [dlss_pkg::TimeBits-1:0] time_inc(
    input logic [dlss_pkg::TimeBits-1:0] t
  );
    return (t == TimeMax) ? t : t + 1'b1;
  endfunction

  function automatic logic time_reached(
    input logic [dlss_pkg::TimeBits-1:0] t,
    input logic [dlss_pkg::CfgDataW-1:0] lim
  );
    return dlss_pkg::TimeCmpW'(t) >= dlss_pkg::TimeCmpW'(lim);
  endfunction

  assign limit_pos  = $signed({1'b0, cfg_i.hyst_limit});
  assign limit_neg  = -limit_pos;
  assign in_range   = (dlss_pkg::PerCmpW'(item_i.period) >= dlss_pkg::PerCmpW'(cfg_i.min_period))
                   && (dlss_pkg::PerCmpW'(item_i.period) <= dlss_pkg::PerCmpW'(cfg_i.max_period));
  assign check_inc  = time_inc(check_q);
  assign win_inc    = time_inc(win_q);
  assign settle_inc = time_inc(settle_q);

  always_comb begin
    hyst_d     = hyst_q;
    door_d     = door_q;
    resolved_d = resolved_q;
    settle_d   = settle_q;
    check_d    = check_q;
    seen_d     = seen_q;
    healthy_d  = healthy_q;
    win_open_d = win_open_q;
    win_d      = win_q;
    triac_d    = triac_q;

    case (item_i.req_type)
      dlss_pkg::REQ_CAPTURE: begin
        seen_d = 1'b1;
        if (in_range && (hyst_q < limit_pos)) begin
          hyst_d = hyst_q + $signed(dlss_pkg::HystW'(1));
        end
      end
      dlss_pkg::REQ_OVERFLOW: begin
        seen_d = 1'b1;
        if (hyst_q > limit_neg) begin
          hyst_d = hyst_q - $signed(dlss_pkg::HystW'(1));
        end
      end
      dlss_pkg::REQ_TICK: begin
        check_d = check_inc;
        if (time_reached(check_inc, cfg_i.check_interval_ms)) begin
          if (!seen_q) begin
            healthy_d = 1'b0;
          end
          seen_d  = 1'b0;
          check_d = '0;
        end
        if (win_open_q) begin
          win_d = win_inc;
          if (time_reached(win_inc, cfg_i.request_window_ms)) begin
            win_open_d = 1'b0;
          end
        end
        if (item_i.relay_state == dlss_pkg::RelayOff) begin
          settle_d   = '0;
          door_d     = dlss_pkg::LOCK_UNKNOWN;
          resolved_d = 1'b0;
        end else begin
          settle_d = settle_inc;
          if ((item_i.relay_state != dlss_pkg::RelayUnknown)
              && (resolved_q || time_reached(settle_inc, cfg_i.settle_ms))) begin
            resolved_d = 1'b1;
            if (!healthy_d || (hyst_q <= limit_neg)) begin
              door_d = dlss_pkg::LOCK_UNLOCKED;
            end else if (hyst_q >= limit_pos) begin
              door_d = dlss_pkg::LOCK_LOCKED;
            end
          end
        end
      end
      dlss_pkg::REQ_RESPONSE: begin
        if ((item_i.response_code == dlss_pkg::RespGrantA)
            || (item_i.response_code == dlss_pkg::RespGrantB)) begin
          win_open_d = 1'b1;
          win_d      = '0;
        end else if (item_i.response_code[dlss_pkg::RespDenyBit]) begin
          win_open_d = 1'b0;
        end
      end
      dlss_pkg::REQ_TRIAC_SET: begin
        if (healthy_q && win_open_q && !time_reached(win_q, cfg_i.request_window_ms)) begin
          triac_d = item_i.triac_request;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hyst_q     <= '0;
      door_q     <= dlss_pkg::LOCK_UNKNOWN;
      resolved_q <= 1'b0;
      settle_q   <= '0;
      check_q    <= '0;
      seen_q     <= 1'b0;
      healthy_q  <= 1'b1;
      win_open_q <= 1'b0;
      win_q      <= '0;
      triac_q    <= 1'b0;
    end else if (step_i) begin
      hyst_q     <= hyst_d;
      door_q     <= door_d;
      resolved_q <= resolved_d;
      settle_q   <= settle_d;
      check_q    <= check_d;
      seen_q     <= seen_d;
      healthy_q  <= healthy_d;
      win_open_q <= win_open_d;
      win_q      <= win_d;
      triac_q    <= triac_d;
    end
  end

  always_comb begin
    result_o.lock_state   = door_d;
    result_o.triac_on     = triac_d;
    result_o.timer_ok     = healthy_d;
    result_o.request_open = win_open_d;
    result_o.hyst_count   = hyst_d;
  end

endmodule

// ----- rtl/door_lock_signal_supervisor.sv -----
// Supervises a door-lock indicator and gates the lock triac. Each input word is a capture,
// overflow, millisecond tick, user response or triac set request (selected by tuser) and
// yields exactly one output word carrying the lock state, triac level, timer health,
// request window flag and hysteresis count after that word was applied. One word is taken
// per clock cycle while the output is not stalled; a word passes through an input register
// and the state update into the output register, from which its result is presented.
// Configuration writes take effect on the next cycle and should only be issued while no
// words are in flight.
module door_lock_signal_supervisor (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dlss_pkg::CfgIdxW-1:0]    cfg_addr_i,
  input  logic [dlss_pkg::CfgDataW-1:0]   cfg_data_i,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // period, relay_state, response_code, triac_request, zero fill
  input  logic [dlss_pkg::InDataW-1:0]    s_axis_tdata,
  // req_type
  input  logic [dlss_pkg::ReqTypeW-1:0]   s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // lock_state, triac_on, timer_ok, request_open, hyst_count, zero fill
  output logic [dlss_pkg::OutDataW-1:0]   m_axis_tdata
);

  dlss_pkg::cfg_t    cfg;
  dlss_pkg::item_t   item_q, item_d;
  dlss_pkg::result_t result;
  dlss_pkg::result_t out_q;
  logic              in_valid_q, in_valid_d;
  logic              out_valid_q, out_valid_d;
  logic              s_accept;
  logic              advance;

  dlss_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_addr_i (cfg_addr_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  dlss_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (advance),
    .item_i   (item_q),
    .cfg_i    (cfg),
    .result_o (result)
  );

  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign in_valid_d    = s_accept || (in_valid_q && !advance);
  assign out_valid_d   = advance || (out_valid_q && !m_axis_tready);

  always_comb begin
    item_d.req_type      = s_axis_tuser;
    item_d.period        = s_axis_tdata[dlss_pkg::PeriodBits-1:0];
    item_d.relay_state   = s_axis_tdata[dlss_pkg::InRelayLsb +: dlss_pkg::RelayW];
    item_d.response_code = s_axis_tdata[dlss_pkg::InRespLsb +: dlss_pkg::RespW];
    item_d.triac_request = s_axis_tdata[dlss_pkg::InTreqLsb];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      item_q <= item_d;
    end
    if (advance) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = dlss_pkg::OutDataW'({out_q.hyst_count, out_q.request_open,
                                              out_q.timer_ok, out_q.triac_on,
                                              out_q.lock_state});

endmodule

// ----- rtl/dlss_checker.sv -----
module dlss_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [dlss_pkg::OutDataW-1:0]   m_axis_tdata
);

  localparam int unsigned HystLsb = 5;

  // The lock state code never takes the unused value.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[1:0] != 2'd3))
    else $error("lock state code out of range");

  // The hysteresis count stays within plus and minus fifteen.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[HystLsb +: dlss_pkg::HystW] != 5'b10000))
    else $error("hysteresis count out of range");

  // A timer fault is latched: the word after a faulted word is faulted too.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && !m_axis_tdata[3])
      |=> (!m_axis_tvalid || !m_axis_tdata[3]))
    else $error("timer fault cleared without reset");

  // A stalled output word holds.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
    else $error("output word changed while stalled");

endmodule

bind door_lock_signal_supervisor dlss_checker u_dlss_checker (.*);

// ----- verif/lock_supervisor_checker.sv -----
module lock_supervisor_checker
  import dlss_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_addr_i,
  input  logic [CfgDataW-1:0] cfg_data_i,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [InDataW-1:0]  s_tdata_i,
  input  logic [ReqTypeW-1:0] s_tuser_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [OutDataW-1:0] m_tdata_i,
  output int                  fail_count_o,
  output int                  outstanding_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [TimeBits-1:0] TimeTop = '1;
  localparam int unsigned TriacBit = 2;
  localparam int unsigned TimerBit = 3;
  localparam int unsigned OpenBit  = 4;
  localparam int unsigned HystLsb  = 5;

  logic [CfgDataW-1:0] min_period, max_period, check_ivl, window_len, settle_len;
  logic [LimitW-1:0]   hyst_lim;

  int                  hyst;
  lock_state_e         door;
  bit                  resolved, events_seen, healthy, window_open, triac;
  logic [TimeBits-1:0] settle_t, check_t, window_t;

  result_t expected_states[$];
  int      fails = 0;
  int      pending = 0;

  assign fail_count_o  = fails;
  assign outstanding_o = pending;

  function automatic logic [TimeBits-1:0] sat_inc(logic [TimeBits-1:0] t);
    return (t == TimeTop) ? t : t + 1'b1;
  endfunction

  // A timer fault always resolves to unlocked.
  function automatic lock_state_e resolved_lock();
    if (!healthy) return LOCK_UNLOCKED;
    if (hyst <= -int'(hyst_lim)) return LOCK_UNLOCKED;
    if (hyst >= int'(hyst_lim)) return LOCK_LOCKED;
    return door;
  endfunction

  function automatic void ms_tick(logic [RelayW-1:0] relay);
    check_t = sat_inc(check_t);
    if (check_t >= check_ivl) begin
      if (!events_seen) healthy = 1'b0;
      events_seen = 1'b0;
      check_t     = '0;
    end
    if (window_open) begin
      window_t = sat_inc(window_t);
      if (window_t >= window_len) window_open = 1'b0;
    end
    if (relay == RelayOff) begin
      settle_t = '0;
      door     = LOCK_UNKNOWN;
      resolved = 1'b0;
    end else begin
      settle_t = sat_inc(settle_t);
      if (relay != RelayUnknown && (resolved || settle_t >= settle_len)) begin
        door     = resolved_lock();
        resolved = 1'b1;
      end
    end
  endfunction

  function automatic result_t supervisor_step(logic [ReqTypeW-1:0] kind,
                                              logic [PeriodBits-1:0] period,
                                              logic [RelayW-1:0] relay,
                                              logic [RespW-1:0] resp,
                                              logic treq);
    result_t r;
    case (kind)
      REQ_CAPTURE: begin
        events_seen = 1'b1;
        if (period >= min_period && period <= max_period && hyst < int'(hyst_lim)) hyst++;
      end
      REQ_OVERFLOW: begin
        events_seen = 1'b1;
        if (hyst > -int'(hyst_lim)) hyst--;
      end
      REQ_TICK: ms_tick(relay);
      REQ_RESPONSE: begin
        if (resp == RespGrantA || resp == RespGrantB) begin
          window_open = 1'b1;
          window_t    = '0;
        end else if (resp[RespDenyBit]) begin
          window_open = 1'b0;
        end
      end
      REQ_TRIAC_SET: begin
        if (healthy && window_open && window_t < window_len) triac = treq;
      end
      default: ;
    endcase
    r.lock_state   = door;
    r.triac_on     = triac;
    r.timer_ok     = healthy;
    r.request_open = window_open;
    r.hyst_count   = HystW'(hyst);
    return r;
  endfunction

  function automatic void check_field(string what, int want, int got);
    if (want != got) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
      fails++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    result_t want;
    if (!rst_ni) begin
      min_period  = MinPeriodRst;
      max_period  = MaxPeriodRst;
      hyst_lim    = HystLimitRst;
      check_ivl   = CheckIntervalRst;
      window_len  = ReqWindowRst;
      settle_len  = SettleRst;
      hyst        = 0;
      door        = LOCK_UNKNOWN;
      resolved    = 1'b0;
      settle_t    = '0;
      check_t     = '0;
      events_seen = 1'b0;
      healthy     = 1'b1;
      window_open = 1'b0;
      window_t    = '0;
      triac       = 1'b0;
      expected_states.delete();
    end else begin
      if (m_tvalid_i && m_tready_i) begin
        if (expected_states.size() == 0) begin
          $display("%0t: result word %h with nothing expected", $time, m_tdata_i);
          fails++;
        end else begin
          want = expected_states.pop_front();
          check_field("lock_state", int'(want.lock_state), int'(m_tdata_i[1:0]));
          check_field("triac_on", int'(want.triac_on), int'(m_tdata_i[TriacBit]));
          check_field("timer_ok", int'(want.timer_ok), int'(m_tdata_i[TimerBit]));
          check_field("request_open", int'(want.request_open), int'(m_tdata_i[OpenBit]));
          check_field("hyst_count", int'(want.hyst_count),
                      int'($signed(m_tdata_i[HystLsb +: HystW])));
        end
      end
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_MIN_PERIOD:     min_period = cfg_data_i;
          CFG_MAX_PERIOD:     max_period = cfg_data_i;
          CFG_HYST_LIMIT:     hyst_lim   = cfg_data_i[LimitW-1:0];
          CFG_CHECK_INTERVAL: check_ivl  = cfg_data_i;
          CFG_REQ_WINDOW:     window_len = cfg_data_i;
          CFG_SETTLE:         settle_len = cfg_data_i;
          default: ;
        endcase
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_states.push_back(supervisor_step(s_tuser_i,
                                                  s_tdata_i[InRelayLsb-1:0],
                                                  s_tdata_i[InRespLsb-1:InRelayLsb],
                                                  s_tdata_i[InTreqLsb-1:InRespLsb],
                                                  s_tdata_i[InTreqLsb]));
      end
    end
    pending = expected_states.size();
  end

endmodule

// ----- verif/tb_top.sv -----
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import dlss_pkg::*;

  localparam logic [RelayW-1:0] RelayOn     = 2'd1;
  localparam logic [RelayW-1:0] RelayOnAlt  = 2'd3;
  localparam int unsigned       StallAfter  = 300;
  localparam int unsigned       StallCycles = 200;

  logic                clk = 1'b0;
  logic                rst_n = 1'b0;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_addr = '0;
  logic [CfgDataW-1:0] cfg_data = '0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [InDataW-1:0]  s_axis_tdata = '0;
  logic [ReqTypeW-1:0] s_axis_tuser = '0;
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [OutDataW-1:0] m_axis_tdata;

  int fail_count;
  int outstanding;
  bit event_since_tick = 1'b0;
  int calm_left = 0;

  door_lock_signal_supervisor uut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  lock_supervisor_checker u_check (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .cfg_we_i      (cfg_we),
    .cfg_addr_i    (cfg_addr),
    .cfg_data_i    (cfg_data),
    .s_tvalid_i    (s_axis_tvalid),
    .s_tready_i    (s_axis_tready),
    .s_tdata_i     (s_axis_tdata),
    .s_tuser_i     (s_axis_tuser),
    .m_tvalid_i    (m_axis_tvalid),
    .m_tready_i    (m_axis_tready),
    .m_tdata_i     (m_axis_tdata),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic item_t make_word(logic [ReqTypeW-1:0] kind, logic [PeriodBits-1:0] period,
                                      logic [RelayW-1:0] relay, logic [RespW-1:0] resp,
                                      logic treq);
    item_t w;
    w.req_type      = kind;
    w.period        = period;
    w.relay_state   = relay;
    w.response_code = resp;
    w.triac_request = treq;
    return w;
  endfunction

  function automatic int gap_len();
    int r;
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    r = $urandom_range(99);
    if (r < 3) calm_left = 40;
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(3, 1);
    return $urandom_range(40, 10);
  endfunction

  // Unless a timer fault is wanted, every tick follows at least one event since the last tick.
  function automatic item_t random_word(logic [CfgDataW-1:0] minp, logic [CfgDataW-1:0] maxp,
                                        bit may_fault);
    item_t w;
    int    r;
    w.period = PeriodBits'($urandom_range(65535, 0));
    r = $urandom_range(99);
    if (r < 50 && minp <= maxp) begin
      w.period = PeriodBits'($urandom_range(maxp, minp));
    end else if (r < 70) begin
      case ($urandom_range(3))
        0: w.period = minp - 1'b1;
        1: w.period = minp;
        2: w.period = maxp;
        default: w.period = maxp + 1'b1;
      endcase
    end
    r = $urandom_range(99);
    w.relay_state = (r < 65) ? RelayOn : (r < 78) ? RelayOff :
                    (r < 89) ? RelayUnknown : RelayOnAlt;
    r = $urandom_range(99);
    if (r < 40) begin
      w.response_code = $urandom_range(1) ? RespGrantA : RespGrantB;
    end else if (r < 70) begin
      w.response_code = RespW'($urandom_range(255)) | (RespW'(1) << RespDenyBit);
    end else begin
      w.response_code = RespW'($urandom_range(255));
    end
    w.triac_request = 1'($urandom_range(1));
    r = $urandom_range(99);
    if (r < 34) w.req_type = REQ_CAPTURE;
    else if (r < 54) w.req_type = REQ_OVERFLOW;
    else if (r < 82) w.req_type = REQ_TICK;
    else if (r < 90) w.req_type = REQ_RESPONSE;
    else if (r < 97) w.req_type = REQ_TRIAC_SET;
    else w.req_type = REQ_TRIAC_SET + ReqTypeW'($urandom_range(3, 1));
    if (w.req_type == REQ_TICK && !may_fault && !event_since_tick) w.req_type = REQ_CAPTURE;
    return w;
  endfunction

  task automatic put_word(item_t w, int gap);
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_axis_tdata  <= InDataW'({w.triac_request, w.response_code, w.relay_state, w.period});
    s_axis_tuser  <= w.req_type;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk); while (!s_axis_tready);
    if (w.req_type == REQ_TICK) begin
      event_since_tick = 1'b0;
    end else if (w.req_type == REQ_CAPTURE || w.req_type == REQ_OVERFLOW) begin
      event_since_tick = 1'b1;
    end
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    do @(negedge clk); while (outstanding != 0);
    @(posedge clk);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [CfgDataW-1:0] val);
    cfg_we   <= 1'b1;
    cfg_addr <= idx;
    cfg_data <= val;
    @(posedge clk);
  endtask

  task automatic run_phase(logic [CfgDataW-1:0] minp, logic [CfgDataW-1:0] maxp,
                           logic [LimitW-1:0] lim, logic [CfgDataW-1:0] chk,
                           logic [CfgDataW-1:0] win, logic [CfgDataW-1:0] settle,
                           int n_words, bit may_fault);
    wait_drained();
    write_cfg(CFG_MIN_PERIOD, minp);
    write_cfg(CFG_MAX_PERIOD, maxp);
    write_cfg(CFG_HYST_LIMIT, CfgDataW'(lim));
    write_cfg(CFG_CHECK_INTERVAL, chk);
    write_cfg(CFG_REQ_WINDOW, win);
    write_cfg(CFG_SETTLE, settle);
    cfg_we <= 1'b0;
    repeat (n_words) put_word(random_word(minp, maxp, may_fault), gap_len());
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    run_phase(16'd0, 16'd20000, 4'd2, 16'd0, 16'd3, 16'd0, 0, 1'b0);
    put_word(make_word(REQ_CAPTURE, 16'd0, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_CAPTURE, 16'hFFFF, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_TICK, 16'd0, RelayUnknown, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_OVERFLOW, 16'd0, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_TICK, 16'd0, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_CAPTURE, 16'd20000, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_CAPTURE, 16'd19999, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_TICK, 16'd0, RelayOnAlt, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_RESPONSE, 16'd0, RelayOn, RespGrantA, 1'b0), gap_len());
    put_word(make_word(REQ_TRIAC_SET, 16'd0, RelayOn, 8'd0, 1'b1), gap_len());
    put_word(make_word(REQ_RESPONSE, 16'd0, RelayOn, RespW'(1) << RespDenyBit, 1'b0),
             gap_len());
    put_word(make_word(REQ_TRIAC_SET, 16'd0, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_RESPONSE, 16'd0, RelayOn, RespGrantB, 1'b0), gap_len());
    put_word(make_word(REQ_RESPONSE, 16'd0, RelayOn, 8'd5, 1'b0), gap_len());
    put_word(make_word(REQ_TRIAC_SET, 16'd0, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_CAPTURE, 16'd20001, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_TICK, 16'd0, RelayOff, 8'd0, 1'b0), gap_len());
    for (int k = 1; k <= 3; k++) begin
      put_word(make_word(REQ_TRIAC_SET + ReqTypeW'(k), '1, '1, '1, 1'b1), gap_len());
    end
    repeat (5) put_word(make_word(REQ_OVERFLOW, 16'd0, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_TICK, 16'd0, RelayOn, 8'd0, 1'b0), gap_len());
    put_word(make_word(REQ_TRIAC_SET, 16'd0, RelayOn, 8'd0, 1'b1), gap_len());

    run_phase(16'd15300, 16'd22200, 4'd2, 16'd100, 16'd4000, 16'd300, 150, 1'b0);
    run_phase(16'd0, 16'hFFFF, 4'd15, 16'hFFFF, 16'hFFFF, 16'hFFFF, 100, 1'b0);
    run_phase(16'd100, 16'd200, 4'd1, 16'd1, 16'd1, 16'd0, 150, 1'b0);
    run_phase(16'd1000, 16'd3000, 4'd3, 16'd5, 16'd20, 16'd4, 200, 1'b0);
    run_phase(16'hFFFF, 16'hFFFF, 4'd7, 16'd0, 16'd0, 16'd2, 100, 1'b0);
    run_phase(16'd40000, 16'd10000, 4'd4, 16'd3, 16'd8, 16'd1, 100, 1'b0);
    run_phase(16'd500, 16'd60000, 4'd1, 16'd2, 16'd6, 16'd3, 250, 1'b1);

    wait_drained();
    repeat (8) @(posedge clk);
    if (fail_count == 0 && outstanding == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Result side: random ready pattern with one long hold-off to back the block up.
  initial begin : drain_results
    int seen;
    int len;
    int r;
    bit stalled;
    seen    = 0;
    stalled = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      r = $urandom_range(99);
      if (!stalled && seen >= StallAfter) begin
        stalled = 1'b1;
        len     = StallCycles;
        m_axis_tready <= 1'b0;
      end else if (r < 55) begin
        len = $urandom_range(20, 1);
        m_axis_tready <= 1'b1;
      end else if (r < 62) begin
        len = $urandom_range(80, 40);
        m_axis_tready <= 1'b1;
      end else if (r < 95) begin
        len = $urandom_range(4, 1);
        m_axis_tready <= 1'b0;
      end else begin
        len = $urandom_range(40, 10);
        m_axis_tready <= 1'b0;
      end
      repeat (len) begin
        @(posedge clk);
        if (m_axis_tvalid && m_axis_tready) seen++;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

endmodule
